FILE: hw/rtl/tvls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvls_pkg
// shared types and constants of the twist velocity limit scaler
// ----------------------------------------------------------------------------
package tvls_pkg;

  localparam int DW = 32;        // twist component width, q16.16
  localparam int LW = DW - 1;    // angular norm limit width
  localparam int PW = 2 * DW;    // product width
  localparam int NLIN = 3;

  typedef logic signed [DW-1:0] data_t;

  // one linear axis candidate factor num/den, neg marks a negative factor
  typedef struct packed {
    logic          neg;
    logic [DW-1:0] num;
    logic [DW-1:0] den;
  } cand_t;

  typedef enum logic [2:0] {
    REG_MAX_LIN_X  = 3'd0,
    REG_MAX_LIN_Y  = 3'd1,
    REG_MAX_LIN_Z  = 3'd2,
    REG_MIN_LIN_X  = 3'd3,
    REG_MIN_LIN_Y  = 3'd4,
    REG_MIN_LIN_Z  = 3'd5,
    REG_MAX_ANG    = 3'd6
  } reg_idx_t;

  localparam data_t          RST_MAX_LIN = 32'sd65536;
  localparam data_t          RST_MIN_LIN = -32'sd65536;
  localparam logic [LW-1:0]  RST_MAX_ANG = 31'd65536;

  localparam logic [DW-1:0]  ONE = 32'd1;

endpackage

FILE: hw/rtl/tvls_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvls_lane
// one linear axis: checks the limits and forms the candidate factor
// ----------------------------------------------------------------------------
module tvls_lane import tvls_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  data_t v,
  input  data_t hi,
  input  data_t lo,
  output cand_t cand
);

  logic              above, below;
  data_t             lim;
  logic signed [DW:0] n, d;
  cand_t             cand_next;

  assign above = v > hi;
  assign below = v < lo;
  assign lim   = above ? hi : lo;

  always_comb begin
    n = lim;
    d = v;
    if (v < 0) begin
      n = -n;
      d = -d;
    end
    cand_next.neg = 1'b0;
    cand_next.num = ONE;
    cand_next.den = ONE;
    if (above || below) begin
      if (v == 0) begin
        // zero divisor: only negative infinity matters
        cand_next.neg = lim < 0;
      end else if (n < 0) begin
        cand_next.neg = 1'b1;
      end else begin
        cand_next.num = n[DW-1:0];
        cand_next.den = d[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cand <= cand_next;
    end
  end

endmodule

FILE: hw/rtl/tvls_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvls_merge
// picks the smallest of the three lane factors by cross multiplication
// ----------------------------------------------------------------------------
module tvls_merge import tvls_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  cand_t c0,
  input  cand_t c1,
  input  cand_t c2,
  output cand_t best
);

  cand_t          w, c2_q;
  cand_t          w_next, best_next;
  logic [PW-1:0]  pa, pb, qa, qb;

  assign pa = c1.num * c0.den;
  assign pb = c0.num * c1.den;
  assign qa = c2_q.num * w.den;
  assign qb = w.num * c2_q.den;

  always_comb begin
    w_next        = (pa < pb) ? c1 : c0;
    w_next.neg    = c0.neg | c1.neg;
    best_next     = (qa < qb) ? c2_q : w;
    best_next.neg = w.neg | c2_q.neg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w    <= w_next;
      c2_q <= c2;
      best <= best_next;
    end
  end

endmodule

FILE: hw/rtl/tvls_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvls_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module tvls_sqrt import tvls_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [PW-1:0] x,
  output logic [DW-1:0] root
);

  localparam int STEPS = DW;

  logic [DW+1:0] rem_s  [STEPS];
  logic [DW-1:0] root_s [STEPS];
  logic [PW-1:0] x_s    [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [DW+1:0] rem_p;
    logic [DW-1:0] root_p;
    logic [PW-1:0] x_p;
    logic [DW+3:0] cur, trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = x;
    end else begin : g_rest
      assign rem_p  = rem_s[i-1];
      assign root_p = root_s[i-1];
      assign x_p    = x_s[i-1];
    end

    assign cur   = {rem_p, x_p[PW-1 -: 2]};
    assign trial = {2'b00, root_p, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i]  <= ge ? (DW+2)'(cur - trial) : cur[DW+1:0];
        root_s[i] <= {root_p[DW-2:0], ge};
        x_s[i]    <= {x_p[PW-3:0], 2'b00};
      end
    end
  end

  assign root = root_s[STEPS-1];

endmodule

FILE: hw/rtl/tvls_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvls_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module tvls_div import tvls_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [PW-1:0] dvd,
  input  logic [DW-1:0] dvs,
  output logic [DW-1:0] quot
);

  localparam int STEPS = DW;

  logic [DW-1:0] rem_s [STEPS];
  logic [DW-1:0] low_s [STEPS];
  logic [DW-1:0] dvs_s [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [DW-1:0] rem_p, low_p, dvs_p;
    logic [DW:0]   cur;
    logic          ge;

    if (i == 0) begin : g_first
      // upper half is below the divisor since the quotient fits
      assign rem_p = dvd[PW-1:DW];
      assign low_p = dvd[DW-1:0];
      assign dvs_p = dvs;
    end else begin : g_rest
      assign rem_p = rem_s[i-1];
      assign low_p = low_s[i-1];
      assign dvs_p = dvs_s[i-1];
    end

    assign cur = {rem_p, low_p[DW-1]};
    assign ge  = cur >= {1'b0, dvs_p};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i] <= ge ? DW'(cur - {1'b0, dvs_p}) : cur[DW-1:0];
        low_s[i] <= {low_p[DW-2:0], ge};
        dvs_s[i] <= dvs_p;
      end
    end
  end

  assign quot = low_s[STEPS-1];

endmodule

FILE: hw/rtl/twist_velocity_limit_scaler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twist_velocity_limit_scaler_top
// direction preserving velocity limit scaling of a six component twist
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  in      | in  | in_valid/in_ready   | lin_x..lin_z, ang_x..ang_z
//  out     | out | out_valid/out_ready | out_lin_*, out_ang_*, was_scaled,
//          |     |                     | limits_invalid
//  cfg     | in  | cfg_we              | cfg_index, cfg_data
//
//  one item per cycle unless stalled; 3 lane/merge stages, 32 square root
//  stages, one product stage, 32 divider stages and the output register
//  the pipeline moves as a whole; it holds while a result waits on out_ready
//  rst clears the valid bits and loads the default limits
// ----------------------------------------------------------------------------
module twist_velocity_limit_scaler_top import tvls_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [DW-1:0]   cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  data_t           lin_x,
  input  data_t           lin_y,
  input  data_t           lin_z,
  input  data_t           ang_x,
  input  data_t           ang_y,
  input  data_t           ang_z,
  output logic            out_valid,
  input  logic            out_ready,
  output data_t           out_lin_x,
  output data_t           out_lin_y,
  output data_t           out_lin_z,
  output data_t           out_ang_x,
  output data_t           out_ang_y,
  output data_t           out_ang_z,
  output logic            was_scaled,
  output logic            limits_invalid
);

  localparam int SQ_LAT  = DW;
  localparam int DIV_LAT = DW;

  typedef struct packed {
    logic                neg;
    logic                sc;
    logic                fire;
    logic [DW-1:0]       num;
    logic [DW-1:0]       den;
    logic [5:0]          sgn;
    logic [5:0][DW-1:0]  mag;
  } side_t;

  typedef struct packed {
    logic       neg;
    logic       sc;
    logic       fire;
    logic [5:0] sgn;
  } tail_t;

  // configuration
  data_t          max_lin [NLIN];
  data_t          min_lin [NLIN];
  logic [LW-1:0]  max_ang_norm;
  logic [PW-3:0]  lim_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NLIN; k++) begin
        max_lin[k] <= RST_MAX_LIN;
        min_lin[k] <= RST_MIN_LIN;
      end
      max_ang_norm <= RST_MAX_ANG;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MAX_LIN_X: max_lin[0]   <= cfg_data;
        REG_MAX_LIN_Y: max_lin[1]   <= cfg_data;
        REG_MAX_LIN_Z: max_lin[2]   <= cfg_data;
        REG_MIN_LIN_X: min_lin[0]   <= cfg_data;
        REG_MIN_LIN_Y: min_lin[1]   <= cfg_data;
        REG_MIN_LIN_Z: min_lin[2]   <= cfg_data;
        REG_MAX_ANG:   max_ang_norm <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lim_sq <= max_ang_norm * max_ang_norm;
  end

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  data_t in_v [6];
  assign in_v[0] = lin_x;
  assign in_v[1] = lin_y;
  assign in_v[2] = lin_z;
  assign in_v[3] = ang_x;
  assign in_v[4] = ang_y;
  assign in_v[5] = ang_z;

  // stage 1: lanes, magnitudes, squares
  cand_t              cand [NLIN];
  cand_t              best;
  logic               v1, v2, v3;
  logic [5:0]         sgn1, sgn2, sgn3;
  logic [5:0][DW-1:0] mag1, mag2, mag3;
  logic [PW-1:0]      sq1 [3];
  logic [PW-1:0]      sum2, sum3;
  logic               fire3;

  for (genvar k = 0; k < NLIN; k++) begin : g_lane
    tvls_lane u_lane (
      .clk  (clk),
      .en   (en),
      .v    (in_v[k]),
      .hi   (max_lin[k]),
      .lo   (min_lin[k]),
      .cand (cand[k])
    );
  end

  tvls_merge u_merge (
    .clk  (clk),
    .en   (en),
    .c0   (cand[0]),
    .c1   (cand[1]),
    .c2   (cand[2]),
    .best (best)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        sgn1[k] <= in_v[k][DW-1];
        mag1[k] <= in_v[k][DW-1] ? DW'(-in_v[k]) : in_v[k];
      end
      for (int k = 0; k < 3; k++) begin
        sq1[k] <= (in_v[k+3][DW-1] ? DW'(-in_v[k+3]) : DW'(in_v[k+3]))
                * (in_v[k+3][DW-1] ? DW'(-in_v[k+3]) : DW'(in_v[k+3]));
      end
      sgn2  <= sgn1;
      mag2  <= mag1;
      sum2  <= sq1[0] + sq1[1] + sq1[2];
      sgn3  <= sgn2;
      mag3  <= mag2;
      sum3  <= sum2;
      fire3 <= sum2 > {2'b00, lim_sq};
    end
  end

  side_t side3;
  always_comb begin
    side3.neg  = best.neg;
    side3.sc   = best.num < best.den;
    side3.fire = fire3;
    side3.num  = best.num;
    side3.den  = best.den;
    side3.sgn  = sgn3;
    side3.mag  = mag3;
  end

  // square root of the angular sum, side data kept in step
  logic [DW-1:0] root;
  side_t         sline [SQ_LAT];
  logic          sv    [SQ_LAT];

  tvls_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (sum3),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sline[0] <= side3;
      for (int i = 1; i < SQ_LAT; i++) begin
        sline[i] <= sline[i-1];
      end
    end
  end

  // product stage: dividends and divisors for the six components
  side_t         sq_out;
  logic [PW-1:0] dvd_n [6];
  logic [DW-1:0] dvs_n [6];
  logic [PW-1:0] dvd   [6];
  logic [DW-1:0] dvs   [6];
  tail_t         tail_p;
  logic          vp;

  assign sq_out = sline[SQ_LAT-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dvd_n[k]   = sq_out.mag[k] * (sq_out.sc ? sq_out.num : ONE);
      dvs_n[k]   = sq_out.sc ? sq_out.den : ONE;
      dvd_n[k+3] = sq_out.mag[k+3] * (sq_out.fire ? {1'b0, max_ang_norm} : ONE);
      dvs_n[k+3] = (sq_out.fire && root != '0) ? root : ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        dvd[k] <= dvd_n[k];
        dvs[k] <= dvs_n[k];
      end
      tail_p.neg  <= sq_out.neg;
      tail_p.sc   <= sq_out.sc;
      tail_p.fire <= sq_out.fire;
      tail_p.sgn  <= sq_out.sgn;
    end
  end

  // six dividers in parallel
  logic [DW-1:0] quot  [6];
  tail_t         tline [DIV_LAT];
  logic          dv    [DIV_LAT];

  for (genvar k = 0; k < 6; k++) begin : g_div
    tvls_div u_div (
      .clk  (clk),
      .en   (en),
      .dvd  (dvd[k]),
      .dvs  (dvs[k]),
      .quot (quot[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tline[0] <= tail_p;
      for (int i = 1; i < DIV_LAT; i++) begin
        tline[i] <= tline[i-1];
      end
    end
  end

  // valid bits of every stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vp <= 1'b0;
      for (int i = 0; i < SQ_LAT; i++) begin
        sv[i] <= 1'b0;
      end
      for (int i = 0; i < DIV_LAT; i++) begin
        dv[i] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      sv[0] <= v3;
      for (int i = 1; i < SQ_LAT; i++) begin
        sv[i] <= sv[i-1];
      end
      vp    <= sv[SQ_LAT-1];
      dv[0] <= vp;
      for (int i = 1; i < DIV_LAT; i++) begin
        dv[i] <= dv[i-1];
      end
      out_valid <= dv[DIV_LAT-1];
    end
  end

  // output register: sign back on, zero the twist on a negative factor
  tail_t tail_o;
  data_t res_n [6];
  data_t res   [6];

  assign tail_o = tline[DIV_LAT-1];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      if (tail_o.neg) begin
        res_n[k] = '0;
      end else if (tail_o.sgn[k]) begin
        res_n[k] = -data_t'(quot[k]);
      end else begin
        res_n[k] = data_t'(quot[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        res[k] <= res_n[k];
      end
      was_scaled     <= tail_o.neg | tail_o.sc | tail_o.fire;
      limits_invalid <= tail_o.neg;
    end
  end

  assign out_lin_x = res[0];
  assign out_lin_y = res[1];
  assign out_lin_z = res[2];
  assign out_ang_x = res[3];
  assign out_ang_y = res[4];
  assign out_ang_z = res[5];

endmodule

FILE: dv/twist_velocity_limit_scaler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twist_velocity_limit_scaler_checker
// watches the config port and both channels, computes the limited twist for
// every accepted item and compares it field by field with the block's result
// ----------------------------------------------------------------------------
module twist_velocity_limit_scaler_checker import tvls_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [DW-1:0] cfg_data,
  input  logic          in_valid,
  input  logic          in_ready,
  input  data_t         lin_x,
  input  data_t         lin_y,
  input  data_t         lin_z,
  input  data_t         ang_x,
  input  data_t         ang_y,
  input  data_t         ang_z,
  input  logic          out_valid,
  input  logic          out_ready,
  input  data_t         out_lin_x,
  input  data_t         out_lin_y,
  input  data_t         out_lin_z,
  input  data_t         out_ang_x,
  input  data_t         out_ang_y,
  input  data_t         out_ang_z,
  input  logic          was_scaled,
  input  logic          limits_invalid,
  output int            errors,
  output int            pending,
  output int            results_seen
);

  typedef struct {
    data_t v[6];
    logic  scaled;
    logic  inval;
  } twist_res_t;

  data_t         lim_hi[3];
  data_t         lim_lo[3];
  logic [LW-1:0] lim_ang;
  twist_res_t    limited_q[$];

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint scale_toward_zero(longint v, longint unsigned num,
                                               longint unsigned den);
    longint unsigned mag, q;
    mag = (v < 0) ? longint'(-v) : v;
    q = (mag * num) / den;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic twist_res_t limit_twist(data_t t[6]);
    twist_res_t r;
    longint v[6];
    longint unsigned bnum, bden, lim, s, n, a;
    longint hi, lo, l, num, den;
    logic neg, sc;
    bnum = 1; bden = 1; neg = 0; sc = 0;
    for (int k = 0; k < 6; k++) v[k] = t[k];
    for (int k = 0; k < 3; k++) begin
      hi = lim_hi[k];
      lo = lim_lo[k];
      if (v[k] > hi) l = hi;
      else if (v[k] < lo) l = lo;
      else continue;
      if (v[k] == 0) begin
        if (l < 0) neg = 1;
        continue;
      end
      num = l; den = v[k];
      if (den < 0) begin
        num = -num; den = -den;
      end
      if (num < 0) begin
        neg = 1;
        continue;
      end
      if (longint'(num) * bden < bnum * longint'(den)) begin
        bnum = num; bden = den;
      end
    end
    if (neg) begin
      for (int k = 0; k < 6; k++) v[k] = 0;
      sc = 1;
    end else if (bnum < bden) begin
      for (int k = 0; k < 3; k++) v[k] = scale_toward_zero(v[k], bnum, bden);
      sc = 1;
    end
    lim = lim_ang;
    s = 0;
    for (int k = 3; k < 6; k++) begin
      a = (v[k] < 0) ? longint'(-v[k]) : v[k];
      s = s + a * a;
    end
    if (s > lim * lim) begin
      n = root_floor(s);
      if (n == 0) n = 1;
      for (int k = 3; k < 6; k++) v[k] = scale_toward_zero(v[k], lim, n);
      sc = 1;
    end
    for (int k = 0; k < 6; k++) r.v[k] = v[k][DW-1:0];
    r.scaled = sc;
    r.inval = neg;
    return r;
  endfunction

  always @(posedge clk) begin
    data_t t[6];
    data_t got[6];
    twist_res_t e;
    logic bad;
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        lim_hi[k] <= RST_MAX_LIN;
        lim_lo[k] <= RST_MIN_LIN;
      end
      lim_ang <= RST_MAX_ANG;
      limited_q.delete();
      errors <= 0;
      pending <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        got = '{out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z};
        if (limited_q.size() == 0) begin
          if (errors < 10) $display("unexpected result item at %0t", $realtime);
          errors <= errors + 1;
        end else begin
          e = limited_q.pop_front();
          bad = (e.scaled !== was_scaled) || (e.inval !== limits_invalid);
          for (int k = 0; k < 6; k++) if (e.v[k] !== got[k]) bad = 1;
          if (bad) begin
            if (errors < 10)
              $display("mismatch: exp %h %h %h %h %h %h s%b i%b got %h %h %h %h %h %h s%b i%b",
                       e.v[0], e.v[1], e.v[2], e.v[3], e.v[4], e.v[5], e.scaled, e.inval,
                       got[0], got[1], got[2], got[3], got[4], got[5],
                       was_scaled, limits_invalid);
            errors <= errors + 1;
          end
        end
      end
      // the user must do config writes only while idle, which the block does not enforce; predict with current limits
      if (in_valid && in_ready) begin
        t = '{lin_x, lin_y, lin_z, ang_x, ang_y, ang_z};
        limited_q.push_back(limit_twist(t));
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_MAX_LIN_X, REG_MAX_LIN_Y, REG_MAX_LIN_Z: lim_hi[cfg_index] <= cfg_data;
          REG_MIN_LIN_X, REG_MIN_LIN_Y, REG_MIN_LIN_Z: lim_lo[cfg_index - 3] <= cfg_data;
          REG_MAX_ANG: lim_ang <= cfg_data[LW-1:0];
          default: ;
        endcase
      end
      pending <= limited_q.size();
    end
  end

endmodule

FILE: dv/twist_velocity_limit_scaler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twist_velocity_limit_scaler_top_tb
// drives directed and random twists through the limit scaler under several
// limit settings, with bursty input and a stalling receiver
// ----------------------------------------------------------------------------
module twist_velocity_limit_scaler_top_tb;
  import tvls_pkg::*;

  localparam int LATENCY = 69;
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [DW-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  data_t lin_x, lin_y, lin_z, ang_x, ang_y, ang_z;
  data_t out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z;
  logic was_scaled, limits_invalid;
  int errors, pending, results_seen;
  int cycles;
  int items_sent;
  bit hold_off;
  bit long_stall_done;

  twist_velocity_limit_scaler_top dut (.*);
  twist_velocity_limit_scaler_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("twist_velocity_limit_scaler_top_tb: done, errors");
        $finish;
      end
    end
  end

  // receiver: random stall pattern, plus one long hold-off on request
  initial begin
    int hold;
    out_ready = 0;
    long_stall_done = 0;
    forever begin
      @(posedge clk);
      if (hold_off && !long_stall_done) begin
        out_ready <= 0;
        for (hold = 0; hold < 300; hold++) @(posedge clk);
        long_stall_done = 1;
      end
      case ($urandom_range(0, 3))
        0: out_ready <= 1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  function automatic data_t rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
      2: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
      3: return 0;
      4: return $urandom_range(0, 32'h0000_ffff) - 32'h0000_8000;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  // offer one item and wait for acceptance; gap of the given length beforehand
  task automatic send_twist(data_t t[6], int gap);
    for (int g = 0; g < gap; g++) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    {lin_x, lin_y, lin_z, ang_x, ang_y, ang_z} <= {t[0], t[1], t[2], t[3], t[4], t[5]};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // write enable drops for one cycle between writes
  task automatic write_limit(reg_idx_t idx, logic [DW-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic random_run(int n);
    data_t t[6];
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 6; k++) t[k] = rand_comp();
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        send_twist(t, $urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
      end else begin
        send_twist(t, 0);
      end
      burst--;
    end
  endtask

  initial begin
    data_t t[6];
    data_t corner[6];
    rst = 1;
    hold_off = 0;
    items_sent = 0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0;
    lin_x = 0; lin_y = 0; lin_z = 0; ang_x = 0; ang_y = 0; ang_z = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed, reset limits: in range, each axis over/under, extremes and
    // angular over the norm
    corner = '{32'sh0, 32'sh7fff_ffff, -32'sh8000_0000, 32'sh0001_0000,
               -32'sh0001_0000, 32'sh0002_0000};
    for (int i = 0; i < 6; i++) begin
      t = '{corner[i], corner[(i+1)%6], corner[(i+2)%6],
            corner[(i+3)%6], corner[(i+4)%6], corner[(i+5)%6]};
      send_twist(t, 0);
    end
    send_twist('{32'sh0000_8000, 32'sh0, 32'sh0, 32'sh0000_8000, 32'sh0, 32'sh0}, 1);
    send_twist('{32'sh0003_0000, -32'sh0002_0000, 32'sh0, 32'sh0001_0000,
                 32'sh0001_0000, 32'sh0001_0000}, 0);
    send_twist('{-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
                 -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000}, 0);
    send_twist('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff}, 0);
    drain();

    // negative upper limit: zero value over a negative limit, negative factor
    write_limit(REG_MAX_LIN_X, -32'sd65536);
    write_limit(REG_MIN_LIN_X, -32'sd131072);
    write_limit(REG_MAX_LIN_Y, 32'sh7fff_ffff);
    write_limit(REG_MIN_LIN_Y, 32'sh8000_0000);
    write_limit(REG_MAX_LIN_Z, 32'sd0);
    write_limit(REG_MIN_LIN_Z, 32'sd0);
    write_limit(REG_MAX_ANG, 32'd0);
    send_twist('{32'sh0, 32'sh1, 32'sh1, 32'sh1, 32'sh0, 32'sh0}, 0);
    send_twist('{-32'sh0001_8000, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0}, 0);
    send_twist('{-32'sh0004_0000, 32'sh5, -32'sh0, 32'sh1, -32'sh1, 32'sh0}, 0);
    send_twist('{-32'sh0001_8000, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0}, 0);
    drain();

    // min above max, largest angular limit
    write_limit(REG_MAX_LIN_X, 32'sd65536);
    write_limit(REG_MIN_LIN_X, 32'sd131072);
    write_limit(REG_MAX_LIN_Z, 32'sd65536);
    write_limit(REG_MIN_LIN_Z, -32'sd65536);
    write_limit(REG_MAX_ANG, 32'h7fff_ffff);
    send_twist('{32'sh0001_8000, 32'sh0, 32'sh0, 32'sh7fff_ffff, 32'sh7fff_ffff, 0}, 0);
    send_twist('{32'sh0, 32'sh0, 32'sh0, -32'sh8000_0000, -32'sh8000_0000,
                 -32'sh8000_0000}, 0);
    random_run(100);
    drain();

    // back to a typical setting; long receiver hold-off during this phase
    write_limit(REG_MAX_LIN_X, 32'sd98304);
    write_limit(REG_MIN_LIN_X, -32'sd98304);
    write_limit(REG_MAX_LIN_Y, 32'sd65536);
    write_limit(REG_MIN_LIN_Y, -32'sd32768);
    write_limit(REG_MAX_ANG, 32'd131072);
    hold_off = 1;
    random_run(200);
    drain();

    // random limits
    for (int ph = 0; ph < 3; ph++) begin
      for (int r = 0; r < 6; r++)
        write_limit(reg_idx_t'(r), $urandom_range(0, 1) ? $urandom :
                    ($urandom_range(0, 32'h0004_0000) - 32'h0002_0000));
      write_limit(REG_MAX_ANG, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h40000));
      random_run(50);
      drain();
    end

    $display("sent %0d twists, checked %0d results over several limit settings",
             items_sent, results_seen);
    $display("mismatches: %0d", errors);
    if (errors == 0 && pending == 0)
      $display("twist_velocity_limit_scaler_top_tb: done, clean");
    else
      $display("twist_velocity_limit_scaler_top_tb: done, errors");
    $finish;
  end

endmodule
